/* hdl/bipolar_output_mode_controller_assert.svh */
// Assertion macros for the bipolar output mode controller checker.
// Included by the checker file; depends on nothing else.
`ifndef BIPOLAR_OUTPUT_MODE_CONTROLLER_ASSERT_SVH
`define BIPOLAR_OUTPUT_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BOMC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bipolar output mode controller check failed");

// Next-cycle implication, disabled while reset is high.
`define BOMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bipolar output mode controller check failed");

`endif

/* hdl/bomc_pkg.sv */
// Shared types and constants for the bipolar output mode controller.
// Used by the top level, the register block and the port checker.
`default_nettype none

package bomc_pkg;

   // Width of the elapsed counters and of the timing registers.
   localparam int CNT_W = 16;

   // Register indexes on the configuration port.
   localparam logic CSR_HALF_PERIOD = 1'b0;
   localparam logic CSR_HOLD_OFF    = 1'b1;

   // Reset values of the timing registers.
   localparam logic [CNT_W-1:0] HALF_PERIOD_RST = 16'd127;
   localparam logic [CNT_W-1:0] HOLD_OFF_RST    = 16'd2000;

   // Operating modes as reported on the result channel.
   typedef enum logic [1:0] {
      MODE_MENU  = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_PAUSE = 2'd2
   } mode_type;

   // Timing configuration handed from the register block to the control logic.
   typedef struct packed {
      logic [CNT_W-1:0] half_period;
      logic [CNT_W-1:0] hold_off;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/bomc_csr.sv */
// Configuration registers of the bipolar output mode controller on an APB-style port.
// Depends on bomc_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module bomc_csr import bomc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   logic             wr_en;
   logic [CNT_W-1:0] half_period_ff;
   logic [CNT_W-1:0] hold_off_ff;

   // The port never inserts wait states.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Register writes in the access cycle; word address sits in bit 2.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RST;
         hold_off_ff    <= HOLD_OFF_RST;
      end else if (wr_en) begin
         if (csr_paddr[2] == CSR_HALF_PERIOD) begin
            half_period_ff <= csr_pwdata[CNT_W-1:0];
         end else begin
            hold_off_ff <= csr_pwdata[CNT_W-1:0];
         end
      end
   end

   // Read data is the selected register, zero extended.
   always_comb begin
      if (csr_paddr[2] == CSR_HALF_PERIOD) begin
         csr_prdata = {{(32-CNT_W){1'b0}}, half_period_ff};
      end else begin
         csr_prdata = {{(32-CNT_W){1'b0}}, hold_off_ff};
      end
   end

   assign cfg.half_period = half_period_ff;
   assign cfg.hold_off    = hold_off_ff;

endmodule

`default_nettype wire

/* hdl/bomc_setpoint.sv */
// Setpoint register with an incrementally tracked duty value for the mode controller.
// Standalone; the top level supplies the step enable and the setpoint limit.
`default_nettype none

module bomc_setpoint #(
   parameter int SETPOINT_MAX = 1000,
   localparam int SP_W = $clog2(SETPOINT_MAX + 1)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   output logic     [SP_W-1:0]  setpoint_in,
   output logic     [7:0]       duty_in
);

   // The duty is setpoint*255/SETPOINT_MAX. The setpoint only ever moves in
   // steps of 50 or restarts at 50, so the quotient and remainder are carried
   // along and each step needs just a constant add and one compare-subtract.
   localparam int R_W      = $clog2(SETPOINT_MAX);
   localparam int STEP     = 50;
   localparam int STEP_NUM = STEP * 255;
   localparam int RST_SP   = 100;
   localparam int RST_NUM  = RST_SP * 255;

   localparam logic [SP_W:0]  STEP_X   = (SP_W+1)'(STEP);
   localparam logic [SP_W:0]  MAX_X    = (SP_W+1)'(SETPOINT_MAX);
   localparam logic [SP_W-1:0] SP_WRAP = SP_W'(STEP);
   localparam logic [SP_W-1:0] SP_RST  = SP_W'(RST_SP);
   localparam logic [7:0]     Q_STEP   = 8'(STEP_NUM / SETPOINT_MAX);
   localparam logic [R_W:0]   R_STEP   = (R_W+1)'(STEP_NUM % SETPOINT_MAX);
   localparam logic [R_W:0]   R_MOD    = (R_W+1)'(SETPOINT_MAX);
   localparam logic [7:0]     Q_RST    = 8'(RST_NUM / SETPOINT_MAX);
   localparam logic [R_W-1:0] R_RST    = R_W'(RST_NUM % SETPOINT_MAX);

   logic [SP_W-1:0] setpoint_ff;
   logic [7:0]      duty_ff;
   logic [R_W-1:0]  rem_ff;
   logic [R_W-1:0]  rem_in;
   logic [SP_W:0]   sp_sum;
   logic [R_W:0]    rem_sum;
   logic [R_W:0]    rem_adj;
   logic            carry;

   // Next setpoint and duty; without a step they hold their values.
   always_comb begin
      sp_sum  = {1'b0, setpoint_ff} + STEP_X;
      rem_sum = {1'b0, rem_ff} + R_STEP;
      carry   = (rem_sum >= R_MOD);
      rem_adj = carry ? (rem_sum - R_MOD) : rem_sum;

      setpoint_in = setpoint_ff;
      duty_in     = duty_ff;
      rem_in      = rem_ff;
      if (step_en) begin
         if (sp_sum > MAX_X) begin
            // Past the limit the setpoint restarts at one step.
            setpoint_in = SP_WRAP;
            duty_in     = Q_STEP;
            rem_in      = R_STEP[R_W-1:0];
         end else begin
            setpoint_in = sp_sum[SP_W-1:0];
            duty_in     = duty_ff + Q_STEP + {7'b0, carry};
            rem_in      = rem_adj[R_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SP_RST;
         duty_ff     <= Q_RST;
         rem_ff      <= R_RST;
      end else begin
         setpoint_ff <= setpoint_in;
         duty_ff     <= duty_in;
         rem_ff      <= rem_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/bipolar_output_mode_controller.sv */
// Top level of the bipolar output mode controller: tick handshake, mode logic, result register.
// Depends on bomc_pkg, bomc_csr and bomc_setpoint.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  touch_mode, touch_power, touch_start
//   rsp_     out        rsp_valid / rsp_stall  bridge_a, bridge_b, duty, power_hold,
//                                              mode, setpoint
//   csr_     in         APB psel/penable       half_period_ms (0x0), hold_off_ms (0x4)
//
// One request per clock unless a stalled result holds it back; the result register loads its result.
// The state update loops through the state registers; the result register takes a copy of it.
// Reset is synchronous and restores all state but the result payload, and both timing registers.
// A request is taken whenever the result register is empty or its result leaves in the
// same cycle, so a stalled result holds back new requests only while it waits.
`default_nettype none

module bipolar_output_mode_controller import bomc_pkg::*; #(
   parameter int SETPOINT_MAX = 1000,
   localparam int SP_W = $clog2(SETPOINT_MAX + 1)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   // Tick requests
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic            req_touch_mode,
   input  wire logic            req_touch_power,
   input  wire logic            req_touch_start,
   // Results
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic                 rsp_bridge_a,
   output logic                 rsp_bridge_b,
   output logic     [7:0]       rsp_duty,
   output logic                 rsp_power_hold,
   output logic     [1:0]       rsp_mode,
   output logic     [SP_W-1:0]  rsp_setpoint,
   // Configuration
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [2:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic      [31:0]     csr_prdata,
   output logic                 csr_pready
);

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   cfg_type          cfg;
   logic             accept;
   logic             step_en;
   logic [SP_W-1:0]  setpoint_in;
   logic [7:0]       duty_next;

   mode_type         mode_ff,          mode_in;
   logic             prev_mode_ff,     prev_mode_in;
   logic             prev_start_ff,    prev_start_in;
   logic             polarity_ff,      polarity_in;
   logic             leg_a_ff,         leg_a_in;
   logic             leg_b_ff,         leg_b_in;
   logic [CNT_W-1:0] since_flip_ff,    since_flip_in;
   logic             press_active_ff,  press_active_in;
   logic [CNT_W-1:0] press_ticks_ff,   press_ticks_in;
   logic             halted_ff,        halted_in;
   logic [CNT_W-1:0] press_inc;
   logic [CNT_W-1:0] since_inc;
   logic             halt_now;

   logic             rsp_valid_ff,     rsp_valid_in;
   logic             rsp_bridge_a_ff;
   logic             rsp_bridge_b_ff;
   logic [7:0]       rsp_duty_ff,      rsp_duty_in;
   logic             rsp_power_hold_ff;
   logic [1:0]       rsp_mode_ff;
   logic [SP_W-1:0]  rsp_setpoint_ff;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // Configuration registers.
   bomc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Setpoint and duty tracking.
   bomc_setpoint #(.SETPOINT_MAX(SETPOINT_MAX)) u_setpoint (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .setpoint_in (setpoint_in),
      .duty_in     (duty_next)
   );

   // A request is taken unless a waiting result is stalled.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Per-tick state update: power hold first, then touch one, touch three, bridge timing.
   always_comb begin
      press_inc = sat_inc(press_ticks_ff);
      since_inc = sat_inc(since_flip_ff);
      halt_now  = req_touch_power & press_active_ff & (press_inc >= cfg.hold_off);

      mode_in         = mode_ff;
      prev_mode_in    = prev_mode_ff;
      prev_start_in   = prev_start_ff;
      polarity_in     = polarity_ff;
      leg_a_in        = leg_a_ff;
      leg_b_in        = leg_b_ff;
      since_flip_in   = since_flip_ff;
      press_active_in = press_active_ff;
      press_ticks_in  = press_ticks_ff;
      halted_in       = halted_ff;
      step_en         = 1'b0;

      if (!halted_ff) begin
         // Hold timing of touch two.
         if (req_touch_power) begin
            press_active_in = 1'b1;
            press_ticks_in  = press_active_ff ? press_inc : '0;
         end else begin
            press_active_in = 1'b0;
            press_ticks_in  = '0;
         end

         if (halt_now) begin
            halted_in = 1'b1;
            leg_a_in  = 1'b0;
            leg_b_in  = 1'b0;
         end else begin
            // Setpoint step on a rising edge of touch one in menu mode.
            step_en      = accept & req_touch_mode & ~prev_mode_ff & (mode_ff == MODE_MENU);
            prev_mode_in = req_touch_mode;

            // Mode step on a rising edge of touch three.
            if (req_touch_start && !prev_start_ff) begin
               if (mode_ff == MODE_RUN) begin
                  mode_in  = MODE_PAUSE;
                  leg_a_in = 1'b0;
                  leg_b_in = 1'b0;
               end else begin
                  mode_in = MODE_RUN;
               end
            end
            prev_start_in = req_touch_start;

            // Polarity flips once the half period has elapsed while running.
            since_flip_in = since_inc;
            if (mode_in == MODE_RUN && since_inc >= cfg.half_period) begin
               since_flip_in = '0;
               polarity_in   = ~polarity_ff;
               leg_a_in      = ~polarity_ff;
               leg_b_in      = polarity_ff;
            end
         end
      end

      rsp_duty_in = (!halted_in && mode_in == MODE_RUN) ? duty_next : 8'd0;
   end

   // Control state advances once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_MENU;
         prev_mode_ff    <= 1'b0;
         prev_start_ff   <= 1'b0;
         polarity_ff     <= 1'b0;
         leg_a_ff        <= 1'b0;
         leg_b_ff        <= 1'b0;
         since_flip_ff   <= '0;
         press_active_ff <= 1'b0;
         press_ticks_ff  <= '0;
         halted_ff       <= 1'b0;
      end else if (accept) begin
         mode_ff         <= mode_in;
         prev_mode_ff    <= prev_mode_in;
         prev_start_ff   <= prev_start_in;
         polarity_ff     <= polarity_in;
         leg_a_ff        <= leg_a_in;
         leg_b_ff        <= leg_b_in;
         since_flip_ff   <= since_flip_in;
         press_active_ff <= press_active_in;
         press_ticks_ff  <= press_ticks_in;
         halted_ff       <= halted_in;
      end
   end

   // Result register valid: set by a request, cleared when the result leaves.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded only with a new request.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_bridge_a_ff   <= leg_a_in;
         rsp_bridge_b_ff   <= leg_b_in;
         rsp_duty_ff       <= rsp_duty_in;
         rsp_power_hold_ff <= ~halted_in;
         rsp_mode_ff       <= mode_in;
         rsp_setpoint_ff   <= setpoint_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bridge_a   = rsp_bridge_a_ff;
   assign rsp_bridge_b   = rsp_bridge_b_ff;
   assign rsp_duty       = rsp_duty_ff;
   assign rsp_power_hold = rsp_power_hold_ff;
   assign rsp_mode       = rsp_mode_ff;
   assign rsp_setpoint   = rsp_setpoint_ff;

endmodule

`default_nettype wire

/* hdl/bomc_checker.sv */
// Port-level checker for the bipolar output mode controller, bound to the top level.
// Depends on bomc_pkg and the assertion macro header.
`default_nettype none
`include "bipolar_output_mode_controller_assert.svh"

module bomc_checker import bomc_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_bridge_a,
   input wire logic       rsp_bridge_b,
   input wire logic [7:0] rsp_duty,
   input wire logic       rsp_power_hold,
   input wire logic [1:0] rsp_mode
);

   logic off_seen_ff;
   logic off_seen_in;
   logic outputs_off;

   // Remember that a power-off result has been delivered.
   assign off_seen_in = off_seen_ff | (rsp_valid & ~rsp_stall & ~rsp_power_hold);

   // Both legs and the duty are low.
   assign outputs_off = (rsp_duty == 8'd0) & ~rsp_bridge_a & ~rsp_bridge_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_seen_ff <= 1'b0;
      end else begin
         off_seen_ff <= off_seen_in;
      end
   end

   // Once powered off, every later result stays powered off.
   `BOMC_ASSERT_NOW(a_off_sticky, clock, reset, rsp_valid && off_seen_ff, !rsp_power_hold)

   // A powered-off result drives nothing.
   `BOMC_ASSERT_NOW(a_off_quiet, clock, reset, rsp_valid && !rsp_power_hold, outputs_off)

   // Duty is zero outside running mode.
   `BOMC_ASSERT_NOW(a_duty_run, clock, reset, rsp_valid && rsp_mode != MODE_RUN, rsp_duty == 8'd0)

   // A stalled result stays offered.
   `BOMC_ASSERT_NEXT(a_valid_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind bipolar_output_mode_controller bomc_checker u_bomc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_bridge_a   (rsp_bridge_a),
   .rsp_bridge_b   (rsp_bridge_b),
   .rsp_duty       (rsp_duty),
   .rsp_power_hold (rsp_power_hold),
   .rsp_mode       (rsp_mode)
);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the bipolar output mode controller: tick requests, results, CSR port.
// Depends on bomc_pkg and the bipolar_output_mode_controller top level.
module tb_top import bomc_pkg::*; ();

   localparam int SETPOINT_MAX   = 1000;
   localparam int SP_W           = $clog2(SETPOINT_MAX + 1);
   localparam int SETPOINT_RESET = 100;
   localparam int SETPOINT_STEP  = 50;
   localparam int DUTY_FULL      = 255;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [CNT_W-1:0] COUNT_SAT = '1;

   // One expected result of a tick.
   typedef struct {
      logic            bridge_a;
      logic            bridge_b;
      logic [7:0]      duty;
      logic            power_hold;
      mode_type        mode;
      logic [SP_W-1:0] setpoint;
   } tick_result_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic            req_touch_mode = 1'b0;
   logic            req_touch_power = 1'b0;
   logic            req_touch_start = 1'b0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic            rsp_bridge_a;
   logic            rsp_bridge_b;
   logic [7:0]      rsp_duty;
   logic            rsp_power_hold;
   logic [1:0]      rsp_mode;
   logic [SP_W-1:0] rsp_setpoint;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [2:0]      csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   // Predicted controller state and timing configuration.
   logic [CNT_W-1:0] cfg_half_period = HALF_PERIOD_RST;
   logic [CNT_W-1:0] cfg_hold_off    = HOLD_OFF_RST;
   mode_type         ctl_mode        = MODE_MENU;
   logic [SP_W-1:0]  ctl_setpoint    = SP_W'(SETPOINT_RESET);
   logic             last_mode_touch = 1'b0;
   logic             last_start_touch = 1'b0;
   logic             pol             = 1'b0;
   logic             leg_a_q         = 1'b0;
   logic             leg_b_q         = 1'b0;
   logic [CNT_W-1:0] flip_count      = '0;
   logic             press_on        = 1'b0;
   logic [CNT_W-1:0] press_count     = '0;
   logic             powered_off     = 1'b0;

   tick_result_type expected_ticks[$];
   tick_result_type oldest_tick;
   int           mismatch_count = 0;
   bit           src_idle_on = 1'b1;
   bit           sink_idle_on = 1'b1;
   int           stall_left = 0;
   int           sink_hold_request = 0;
   int           cycle_count = 0;

   bipolar_output_mode_controller #(.SETPOINT_MAX(SETPOINT_MAX)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_touch_mode  (req_touch_mode),
      .req_touch_power (req_touch_power),
      .req_touch_start (req_touch_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bridge_a    (rsp_bridge_a),
      .rsp_bridge_b    (rsp_bridge_b),
      .rsp_duty        (rsp_duty),
      .rsp_power_hold  (rsp_power_hold),
      .rsp_mode        (rsp_mode),
      .rsp_setpoint    (rsp_setpoint),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   // Advance the predicted controller by one tick and return its outputs.
   function automatic tick_result_type next_tick_outputs(input logic t_mode,
                                                         input logic t_power,
                                                         input logic t_start);
      tick_result_type r;
      int unsigned  next_sp;
      int unsigned  duty_full;
      r.bridge_a   = 1'b0;
      r.bridge_b   = 1'b0;
      r.duty       = '0;
      r.power_hold = 1'b0;
      if (powered_off) begin
         r.mode     = ctl_mode;
         r.setpoint = ctl_setpoint;
         return r;
      end
      // The power touch is checked first; a long enough hold switches off for good.
      if (t_power) begin
         if (!press_on) begin
            press_on    = 1'b1;
            press_count = '0;
         end else begin
            if (press_count != COUNT_SAT) press_count = press_count + 1'b1;
            if (press_count >= cfg_hold_off) begin
               powered_off = 1'b1;
               leg_a_q     = 1'b0;
               leg_b_q     = 1'b0;
               r.mode      = ctl_mode;
               r.setpoint  = ctl_setpoint;
               return r;
            end
         end
      end else begin
         press_on    = 1'b0;
         press_count = '0;
      end
      // Setpoint steps only on a rising mode touch in the menu.
      if (t_mode && !last_mode_touch && ctl_mode == MODE_MENU) begin
         next_sp = ctl_setpoint + SETPOINT_STEP;
         if (next_sp > SETPOINT_MAX) next_sp = SETPOINT_STEP;
         ctl_setpoint = next_sp[SP_W-1:0];
      end
      last_mode_touch = t_mode;
      // Start touch: menu or paused goes to running, running goes to paused.
      if (t_start && !last_start_touch) begin
         if (ctl_mode == MODE_RUN) begin
            ctl_mode = MODE_PAUSE;
            leg_a_q  = 1'b0;
            leg_b_q  = 1'b0;
         end else begin
            ctl_mode = MODE_RUN;
         end
      end
      last_start_touch = t_start;
      if (flip_count != COUNT_SAT) flip_count = flip_count + 1'b1;
      if (ctl_mode == MODE_RUN) begin
         if (flip_count >= cfg_half_period) begin
            flip_count = '0;
            pol        = ~pol;
            leg_a_q    = pol;
            leg_b_q    = ~pol;
         end
         duty_full = (ctl_setpoint * DUTY_FULL) / SETPOINT_MAX;
         r.duty    = (duty_full > DUTY_FULL) ? 8'(DUTY_FULL) : duty_full[7:0];
      end
      r.bridge_a   = leg_a_q;
      r.bridge_b   = leg_b_q;
      r.power_hold = 1'b1;
      r.mode       = ctl_mode;
      r.setpoint   = ctl_setpoint;
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // Compare every accepted result with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ticks.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) $display("result with no request outstanding");
         end else begin
            oldest_tick = expected_ticks.pop_front();
            check_field("bridge_a", oldest_tick.bridge_a, rsp_bridge_a);
            check_field("bridge_b", oldest_tick.bridge_b, rsp_bridge_b);
            check_field("duty", oldest_tick.duty, rsp_duty);
            check_field("power_hold", oldest_tick.power_hold, rsp_power_hold);
            check_field("mode", oldest_tick.mode, rsp_mode);
            check_field("setpoint", oldest_tick.setpoint, rsp_setpoint);
         end
      end
   end

   // Result-side stalls: random bursts, or one long hold when a test asks for it.
   initial begin
      forever begin
         @(posedge clock);
         if (sink_hold_request > 0) begin
            stall_left        = sink_hold_request;
            sink_hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left = pick_gap() - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Offer one tick request and hold it until it is taken.
   task automatic send_tick(input logic t_mode, input logic t_power, input logic t_start);
      int gap;
      expected_ticks.push_back(next_tick_outputs(t_mode, t_power, t_start));
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         gap = pick_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_touch_mode  <= t_mode;
      req_touch_power <= t_power;
      req_touch_start <= t_start;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, access cycle, then an idle cycle.
   task automatic csr_access(input bit is_write, input logic idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write a timing register once the block is idle, read it back and track it.
   task automatic write_timing(input logic idx, input logic [CNT_W-1:0] value);
      logic [31:0] rd;
      wait_drained();
      csr_access(1'b1, idx, {16'b0, value}, rd);
      csr_access(1'b0, idx, '0, rd);
      check_field((idx == CSR_HALF_PERIOD) ? "half_period_ms readback" : "hold_off_ms readback",
                  value, rd);
      if (idx == CSR_HALF_PERIOD) cfg_half_period = value;
      else cfg_hold_off = value;
   endtask

   // Touch levels toggle after random hold and release times; some ticks are pure noise.
   // Bit 0 is the mode touch, bit 1 the power touch, bit 2 the start touch.
   task automatic random_ticks(input int count);
      logic [2:0] level;
      logic [2:0] lv;
      int         left [3];
      level = '0;
      left  = '{default: 0};
      for (int i = 0; i < count; i++) begin
         for (int k = 0; k < 3; k++) begin
            if (left[k] == 0) begin
               level[k] = ~level[k];
               left[k]  = level[k] ? pick_gap() : $urandom_range(1, (k == 2) ? 40 : 10);
            end
            left[k]--;
         end
         lv = level;
         if ($urandom_range(0, 9) == 0) lv = 3'($urandom);
         // Keep the power touch short of the hold-off so the block stays on.
         if (lv[1] && press_on && press_count + 1 >= cfg_hold_off) lv[1] = 1'b0;
         send_tick(lv[0], lv[1], lv[2]);
      end
   endtask

   task automatic test_reset_state();
      logic [31:0] rd;
      csr_access(1'b0, CSR_HALF_PERIOD, '0, rd);
      check_field("half_period_ms after reset", HALF_PERIOD_RST, rd);
      csr_access(1'b0, CSR_HOLD_OFF, '0, rd);
      check_field("hold_off_ms after reset", HOLD_OFF_RST, rd);
      repeat (4) send_tick(1'b0, 1'b0, 1'b0);
   endtask

   // Menu setpoint steps, including the wrap past the top back to the lowest step.
   task automatic test_setpoint_wrap();
      int extra;
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      repeat (19) begin
         send_tick(1'b1, 1'b0, 1'b0);
         send_tick(1'b0, 1'b0, 1'b0);
      end
      // Leave the setpoint at a random step, with power taps mixed in.
      extra = $urandom_range(0, 19);
      repeat (extra) begin
         send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0);
         send_tick(1'b0, 1'b0, 1'b0);
      end
   endtask

   task automatic test_directed_cases();
      write_timing(CSR_HALF_PERIOD, 16'd1);
      write_timing(CSR_HOLD_OFF, 16'd1);
      // A single held power tick only arms the press; releasing clears it.
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      // Mode and start rising together: the setpoint steps before the block starts.
      send_tick(1'b1, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b1, 1'b1);
      // A mode touch while running changes nothing.
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      // Pause, then resume with flips on every tick.
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);
      // With a longer half period the legs stay low after resuming until the next flip.
      write_timing(CSR_HALF_PERIOD, 16'd4);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      // All touches at once pauses again.
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);
   endtask

   // Longest half period: the legs hold through a resumed stretch and a second pause.
   task automatic test_flip_extremes();
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      write_timing(CSR_HALF_PERIOD, COUNT_SAT);
      repeat (20) send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      repeat (20) send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_random_sessions();
      logic [CNT_W-1:0] hp;
      logic [CNT_W-1:0] ho;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) hp = 16'd1;
         else if (phase == 1) hp = COUNT_SAT;
         else if ($urandom_range(0, 1) == 0) hp = 16'($urandom_range(2, 12));
         else hp = 16'($urandom_range(13, 300));
         if (phase == 2) ho = 16'd1;
         else if (phase == 3) ho = COUNT_SAT;
         else ho = 16'($urandom_range(2, 40));
         write_timing(CSR_HALF_PERIOD, hp);
         write_timing(CSR_HOLD_OFF, ho);
         src_idle_on  = (phase != 4);
         sink_idle_on = (phase != 4);
         random_ticks(190);
      end
   endtask

   // The result side holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      wait_drained();
      src_idle_on       = 1'b0;
      sink_idle_on      = 1'b0;
      sink_hold_request = 300;
      random_ticks(40);
      wait_drained();
   endtask

   // Hold power past a short hold-off; the block switches off and ignores all later ticks.
   task automatic test_power_off();
      logic [CNT_W-1:0] ho;
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      ho = 16'($urandom_range(2, 40));
      write_timing(CSR_HALF_PERIOD, 16'($urandom_range(1, 20)));
      write_timing(CSR_HOLD_OFF, ho);
      repeat (ho) send_tick(1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)));
      send_tick(1'b0, 1'b1, 1'b0);
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      repeat (20)
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_setpoint_wrap();
      test_directed_cases();
      test_flip_extremes();
      test_random_sessions();
      test_backpressure();
      test_power_off();
      wait_drained();
      if (mismatch_count == 0 && expected_ticks.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
